>>> rtl/core/iee_pkg.sv
// Shared types and constants of the infix expression evaluator.
// Operator codes, parse and sequencer states, ASCII codes, helpers.
// No dependencies.
`timescale 1ns / 1ps

package iee_pkg;

  typedef enum logic [2:0] {
    OPC_ADD  = 3'd1,
    OPC_SUB  = 3'd2,
    OPC_MUL  = 3'd3,
    OPC_DIV  = 3'd4,
    OPC_MOD  = 3'd5,
    OPC_LPAR = 3'd6
  } opc_t;

  typedef enum logic [2:0] {
    PS_START = 3'd0,
    PS_INT   = 3'd1,
    PS_FRAC  = 3'd2,
    PS_OPER  = 3'd3,
    PS_RPAR  = 3'd4,
    PS_LPAR  = 3'd5
  } parse_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSHOP,
    ST_RED,
    ST_RED_EX,
    ST_RED_MUL,
    ST_RED_DIV,
    ST_RED_WB,
    ST_OPRD,
    ST_CLOSE,
    ST_FLUSH,
    ST_EMIT
  } fsm_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [1:0] CFG_PREC_ADD_SUB = 2'd0;
  localparam logic [1:0] CFG_PREC_MUL_DIV = 2'd1;
  localparam logic [1:0] CFG_PREC_MOD     = 2'd2;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [3:0] MAX_FRAC_DIGITS = 4'd15;
  // beyond this many fraction digits a digit adds nothing (9 << 24 < 10^9)
  localparam logic [3:0] LAST_DIV_DIGIT  = 4'd8;

  function automatic logic [31:0] pow10(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> rtl/core/iee_div.sv
// Radix-2 restoring divider, 64-bit unsigned dividend by 32-bit divisor.
// One quotient bit per cycle. Uses iee_pkg.
`timescale 1ns / 1ps

module iee_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       dividend,
  input  logic [31:0]       divisor,
  output logic [63:0]       quotient,
  output logic [31:0]       remainder,
  output iee_pkg::div_stat_t stat
);
  import iee_pkg::*;

  logic [63:0] quo;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {rem, quo[63]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      quo <= {quo[62:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat      = '{busy: busy, done: done};

endmodule

>>> rtl/core/infix_expression_evaluator.sv
// Infix expression evaluator: top level, sequencer and stack memories.
// Depends on iee_pkg and iee_div.
//
// Takes ASCII text one character per request on s_axis and returns one
// result request on m_axis per newline: tdata holds the value in signed
// fixed point with FRAC_BITS fraction bits, tuser[0] is 1 for an error
// (value then 0). Numbers, fractions, parentheses, + - * / %, unary minus,
// left associativity and configurable precedence are handled; errors drop
// the rest of the line. A fraction digit is added from a constant table.
// An operator or ')' may trigger reductions; a reduction of * has an extra
// multiply step, and one of / or % runs in the shared radix-2 divider.
// A newline reduces what is left the same way. The stack memories have a
// registered read. A new character is taken while a result still waits
// on m_axis; a second result waits for it.
`timescale 1ns / 1ps

module infix_expression_evaluator #(
  parameter int OP_DEPTH  = 32,
  parameter int NUM_DEPTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic [0:0]  m_axis_tuser,   // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);
  import iee_pkg::*;

  localparam int NCW = $clog2(NUM_DEPTH + 1);
  localparam int NAW = $clog2(NUM_DEPTH);
  localparam int OCW = $clog2(OP_DEPTH + 1);
  localparam int OAW = $clog2(OP_DEPTH);
  localparam logic signed [65:0] TRUNC_ADJ = 66'((64'd1 << FRAC_BITS) - 64'd1);

  // fraction digit increments: slot {k-1, d} holds floor(d * 2^FRAC_BITS / 10^k)
  function automatic logic [128*32-1:0] frac_table();
    logic [128*32-1:0] t;
    t = '0;
    for (int k = 0; k < 8; k++)
      for (int d = 0; d < 10; d++)
        t[(k*16 + d)*32 +: 32] = 32'((64'(d) << FRAC_BITS) / 64'(pow10(4'(k + 1))));
    return t;
  endfunction

  localparam logic [128*32-1:0] FRAC_TAB = frac_table();

  // precedence registers
  logic [1:0] prec_add_sub, prec_mul_div, prec_mod;

  // stacks: entries in memory, top of each mirrored in a register
  logic [31:0] num_mem [NUM_DEPTH];
  opc_t        op_mem  [OP_DEPTH];
  logic [31:0] num_rdata;
  opc_t        op_rdata;
  logic          num_we;
  logic [NAW-1:0] num_waddr;
  logic [31:0]   num_wdata;
  logic          op_we;

  logic [NCW-1:0] ncount, n_m1, n_m2;
  logic [OCW-1:0] ocount, o_m2;
  logic [31:0]    ntop;
  opc_t           otop;

  fsm_t   state, state_next, ret;
  parse_t ps;
  logic [3:0] fd;
  logic   discarding, nl_mode;
  opc_t   pend;
  logic [31:0] rr;
  logic signed [63:0] prod;
  logic   dneg;
  logic [31:0] res_value;
  logic        res_status;
  logic        err;

  // divider
  logic        div_start;
  logic [63:0] div_dnd;
  logic [31:0] div_dsr;
  logic [63:0] div_q;
  logic [31:0] div_r;
  div_stat_t   div_stat;

  iee_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dnd),
    .divisor   (div_dsr),
    .quotient  (div_q),
    .remainder (div_r),
    .stat      (div_stat)
  );

  // character decode
  logic [7:0] ch;
  logic [3:0] dig_val;
  logic acc, nl, live, dig, c_dot, c_lp, c_rp, c_minus, c_binop;
  logic ps_num, ps_after, ps_open, ps_unary;
  logic go_push_num, num_full, upd_int, go_frac, frac_div, go_pushop, go_close;
  logic [31:0] push_val;
  opc_t        bin_code;
  logic [6:0]  frac_idx;
  logic [31:0] frac_add;

  assign ch      = s_axis_tdata;
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign nl      = ch == CH_NL;
  assign live    = acc && !nl && !discarding;
  assign dig     = ch inside {[CH_0:CH_9]};
  assign dig_val = 4'(ch - CH_0);
  assign c_dot   = ch == CH_DOT;
  assign c_lp    = ch == CH_LPAR;
  assign c_rp    = ch == CH_RPAR;
  assign c_minus = ch == CH_MINUS;
  assign c_binop = ch inside {CH_PLUS, CH_STAR, CH_SLASH, CH_PCT};

  always_comb begin
    case (ch)
      CH_PLUS:  bin_code = OPC_ADD;
      CH_STAR:  bin_code = OPC_MUL;
      CH_SLASH: bin_code = OPC_DIV;
      default:  bin_code = OPC_MOD;
    endcase
  end

  assign ps_num   = ps inside {PS_INT, PS_FRAC};
  assign ps_after = ps inside {PS_INT, PS_FRAC, PS_RPAR};
  assign ps_open  = ps inside {PS_START, PS_OPER, PS_LPAR};
  assign ps_unary = ps inside {PS_START, PS_LPAR};

  assign n_m1 = ncount - NCW'(1);
  assign n_m2 = ncount - NCW'(2);
  assign o_m2 = ocount - OCW'(2);

  assign num_full    = ncount >= NCW'(NUM_DEPTH);
  assign go_push_num = live && ((dig && ps_open) || (c_minus && ps_unary));
  assign push_val    = dig ? (32'(dig_val) << FRAC_BITS) : '0;
  assign upd_int     = live && dig && ps == PS_INT && ncount != '0;
  assign go_frac     = live && dig && ps == PS_FRAC && ncount != '0 &&
                       fd < MAX_FRAC_DIGITS;
  assign frac_div    = go_frac && fd < LAST_DIV_DIGIT;
  assign go_pushop   = live && ((c_lp && ps_open) || (c_minus && (ps_unary || ps_after)) ||
                                (c_binop && ps_after));
  assign go_close    = live && c_rp && ps_after;

  // fd is below 8 whenever the table is used, so it indexes the digit position
  assign frac_idx = {fd[2:0], dig_val};
  assign frac_add = FRAC_TAB[{frac_idx, 5'd0} +: 32];

  // precedence compare
  function automatic logic [1:0] lvl(input opc_t c, input logic [1:0] pas,
                                     input logic [1:0] pmd, input logic [1:0] pmo);
    logic [1:0] r;
    case (c)
      OPC_ADD, OPC_SUB: r = pas;
      OPC_MUL, OPC_DIV: r = pmd;
      OPC_MOD:          r = pmo;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  logic need_red, op_full, red_bad;
  assign need_red = ocount != '0 && pend != OPC_LPAR &&
                    !(lvl(pend, prec_add_sub, prec_mul_div, prec_mod) >
                      lvl(otop, prec_add_sub, prec_mul_div, prec_mod));
  assign op_full  = ocount >= OCW'(OP_DEPTH);
  assign red_bad  = ncount < NCW'(2) || ocount == '0 ||
                    !(otop == OPC_ADD || otop == OPC_SUB || otop == OPC_MUL ||
                      otop == OPC_DIV || otop == OPC_MOD);

  // arithmetic
  logic signed [65:0] a_sx, b_sx, top_sx;
  logic [31:0] a_mag, b_mag, ia_mag, ib_mag;
  logic signed [65:0] p_sx, p_adj, mul_res, div_res, mod_res, rem_sx;
  logic [31:0] int_next, frac_next;

  assign a_sx   = {{34{ntop[31]}}, ntop};
  assign b_sx   = {{34{num_rdata[31]}}, num_rdata};
  assign top_sx = a_sx;
  assign a_mag  = ntop[31] ? 32'(-ntop) : ntop;
  assign b_mag  = num_rdata[31] ? 32'(-num_rdata) : num_rdata;
  assign ia_mag = a_mag >> FRAC_BITS;
  assign ib_mag = b_mag >> FRAC_BITS;

  assign p_sx    = {{2{prod[63]}}, prod};
  assign p_adj   = p_sx + (prod[63] ? TRUNC_ADJ : 66'sd0);
  assign mul_res = p_adj >>> FRAC_BITS;
  assign div_res = dneg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign rem_sx  = dneg ? -$signed({34'd0, div_r}) : $signed({34'd0, div_r});
  assign mod_res = rem_sx <<< FRAC_BITS;

  assign int_next  = sat32((top_sx <<< 3) + (top_sx <<< 1) +
                           $signed(66'(dig_val) << FRAC_BITS));
  assign frac_next = sat32(top_sx + $signed({34'd0, frac_add}));

  // next state and error detection
  always_comb begin
    state_next = state;
    err        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (nl) state_next = discarding ? ST_EMIT : ST_FLUSH;
          else if (go_push_num && num_full) err = 1'b1;
          else if (go_pushop) state_next = ST_PUSHOP;
          else if (go_close) state_next = ST_CLOSE;
        end
      end
      ST_PUSHOP: begin
        if (need_red) state_next = ST_RED;
        else if (op_full) err = 1'b1;
        else state_next = ST_IDLE;
      end
      ST_RED: begin
        if (red_bad) err = 1'b1;
        else state_next = ST_RED_EX;
      end
      ST_RED_EX: begin
        case (otop)
          OPC_ADD, OPC_SUB: state_next = ST_RED_WB;
          OPC_MUL:          state_next = ST_RED_MUL;
          OPC_DIV: begin
            if (ntop == '0) err = 1'b1;
            else state_next = ST_RED_DIV;
          end
          OPC_MOD: begin
            if (ia_mag == '0) err = 1'b1;
            else state_next = ST_RED_DIV;
          end
          default: err = 1'b1;
        endcase
      end
      ST_RED_MUL: state_next = ST_RED_WB;
      ST_RED_DIV: if (div_stat.done) state_next = ST_RED_WB;
      ST_RED_WB:  state_next = ST_OPRD;
      ST_OPRD:    state_next = ret;
      ST_CLOSE: begin
        if (ocount == '0) err = 1'b1;
        else if (otop == OPC_LPAR) state_next = ST_OPRD;
        else state_next = ST_RED;
      end
      ST_FLUSH: begin
        if (ocount != '0) state_next = ST_RED;
        else if (ncount == '0) err = 1'b1;
        else state_next = ST_EMIT;
      end
      ST_EMIT: if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (err) state_next = nl_mode ? ST_EMIT : ST_IDLE;
  end

  // memory and divider controls
  always_comb begin
    s_axis_tready = state == ST_IDLE;
    cfg_ready     = 1'b1;
    num_we        = 1'b0;
    num_waddr     = ncount[NAW-1:0];
    num_wdata     = push_val;
    op_we         = 1'b0;
    div_start     = 1'b0;
    div_dnd       = '0;
    div_dsr       = '0;
    case (state)
      ST_IDLE: begin
        if (go_push_num && !num_full) begin
          num_we = 1'b1;
        end else if (upd_int) begin
          num_we    = 1'b1;
          num_waddr = n_m1[NAW-1:0];
          num_wdata = int_next;
        end else if (frac_div) begin
          num_we    = 1'b1;
          num_waddr = n_m1[NAW-1:0];
          num_wdata = frac_next;
        end
      end
      ST_PUSHOP: op_we = !need_red && !op_full;
      ST_RED_EX: begin
        if (otop == OPC_DIV) begin
          div_start = ntop != '0;
          div_dnd   = 64'(b_mag) << FRAC_BITS;
          div_dsr   = a_mag;
        end else if (otop == OPC_MOD) begin
          div_start = ia_mag != '0;
          div_dnd   = 64'(ib_mag);
          div_dsr   = ia_mag;
        end
      end
      ST_RED_WB: begin
        num_we    = 1'b1;
        num_waddr = n_m2[NAW-1:0];
        num_wdata = rr;
      end
      default: ;
    endcase
  end

  // stack memories, registered read
  always_ff @(posedge clk) begin
    if (num_we) num_mem[num_waddr] <= num_wdata;
    num_rdata <= num_mem[n_m2[NAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (op_we) op_mem[ocount[OAW-1:0]] <= pend;
    op_rdata <= op_mem[o_m2[OAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prec_add_sub <= 2'd1;
      prec_mul_div <= 2'd2;
      prec_mod     <= 2'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PREC_ADD_SUB: prec_add_sub <= cfg_data;
        CFG_PREC_MUL_DIV: prec_mul_div <= cfg_data;
        CFG_PREC_MOD:     prec_mod     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      ncount     <= '0;
      ocount     <= '0;
      ps         <= PS_START;
      fd         <= '0;
      discarding <= 1'b0;
      nl_mode    <= 1'b0;
      ret        <= ST_IDLE;
    end else if (err) begin
      ncount <= '0;
      ocount <= '0;
      ps     <= PS_START;
      fd     <= '0;
      if (nl_mode) begin
        res_value  <= '0;
        res_status <= 1'b1;
        nl_mode    <= 1'b0;
        discarding <= 1'b0;
      end else begin
        discarding <= 1'b1;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc && nl) begin
            if (discarding) begin
              res_value  <= '0;
              res_status <= 1'b1;
              discarding <= 1'b0;
              ncount     <= '0;
              ocount     <= '0;
              ps         <= PS_START;
              fd         <= '0;
            end else begin
              nl_mode <= 1'b1;
            end
          end else if (live) begin
            if (go_push_num) begin
              ntop   <= push_val;
              ncount <= ncount + NCW'(1);
              fd     <= '0;
            end
            if (upd_int) ntop <= int_next;
            if (frac_div) ntop <= frac_next;
            if (go_frac) fd <= fd + 4'd1;
            if (dig && ps_open) ps <= PS_INT;
            if (c_dot && ps == PS_INT) ps <= PS_FRAC;
            if (go_pushop) begin
              if (c_lp) begin
                pend <= OPC_LPAR;
                ps   <= PS_LPAR;
              end else begin
                pend <= c_minus ? OPC_SUB : bin_code;
                ps   <= PS_OPER;
              end
            end
            if (go_close) begin
              ps  <= PS_RPAR;
              ret <= ST_CLOSE;
            end
          end
        end
        ST_PUSHOP: begin
          if (need_red) begin
            ret <= ST_PUSHOP;
          end else begin
            otop   <= pend;
            ocount <= ocount + OCW'(1);
          end
        end
        ST_RED_EX: begin
          case (otop)
            OPC_ADD: rr <= sat32(b_sx + a_sx);
            OPC_SUB: rr <= sat32(b_sx - a_sx);
            OPC_MUL: prod <= $signed(num_rdata) * $signed(ntop);
            OPC_DIV: dneg <= ntop[31] ^ num_rdata[31];
            default: dneg <= num_rdata[31];
          endcase
        end
        ST_RED_MUL: rr <= sat32(mul_res);
        ST_RED_DIV: if (div_stat.done) rr <= sat32(otop == OPC_DIV ? div_res : mod_res);
        ST_RED_WB: begin
          ntop   <= rr;
          ncount <= n_m1;
          ocount <= ocount - OCW'(1);
        end
        ST_OPRD: otop <= op_rdata;
        ST_CLOSE: begin
          if (otop == OPC_LPAR) begin
            ocount <= ocount - OCW'(1);
            ret    <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (ocount != '0) begin
            ret <= ST_FLUSH;
          end else begin
            res_value  <= ntop;
            res_status <= 1'b0;
            nl_mode    <= 1'b0;
            ncount     <= '0;
            ps         <= PS_START;
            fd         <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata    <= res_value;
      m_axis_tuser[0] <= res_status;
    end
  end

  // checks
  a_ncount_bound: assert property (@(posedge clk) disable iff (rst)
    ncount <= NCW'(NUM_DEPTH)) else $error("number stack count overran");
  a_ocount_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= OCW'(OP_DEPTH)) else $error("operator stack count overran");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy) else $error("divider started while busy");
  a_err_discard: assert property (@(posedge clk) disable iff (rst)
    (err && !nl_mode) |=> discarding) else $error("error did not start discard");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the infix expression evaluator.
// Depends on iee_pkg and infix_expression_evaluator; drives text lines, predicts results.
`timescale 1ns / 1ps

module testbench;
  import iee_pkg::*;

  localparam int FRAC = 16;
  localparam int DEPTH = 32;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int HOLD_LEN = 2000;

  // Expected output of one line
  typedef struct {
    logic [31:0] value;
    logic        status;
  } line_result_t;

  // Scoreboard: evaluates text with two stacks and holds pending line results
  class line_scoreboard;
    logic [1:0]  prec [3];
    opc_t        ops [DEPTH];
    int          op_cnt;
    logic signed [31:0] nums [DEPTH];
    int          num_cnt;
    parse_t      ps;
    int          frac_cnt;
    bit          dropping;
    line_result_t pending [$];
    int          mismatches;
    int          lines_done;
    int          error_lines;

    function void clear_stacks();
      op_cnt = 0;
      num_cnt = 0;
      ps = PS_START;
      frac_cnt = 0;
    endfunction

    function void init();
      prec[0] = 2'd1;
      prec[1] = 2'd2;
      prec[2] = 2'd3;
      dropping = 0;
      mismatches = 0;
      lines_done = 0;
      error_lines = 0;
      clear_stacks();
    endfunction

    function logic [31:0] clamp(input logic signed [95:0] v);
      if (v > 96'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -96'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function logic [1:0] level(input opc_t code);
      case (code)
        OPC_ADD, OPC_SUB: return prec[CFG_PREC_ADD_SUB];
        OPC_MUL, OPC_DIV: return prec[CFG_PREC_MUL_DIV];
        OPC_MOD:          return prec[CFG_PREC_MOD];
        default:          return 2'd0;
      endcase
    endfunction

    function bit push_number(input logic [31:0] v);
      if (num_cnt >= DEPTH) return 0;
      nums[num_cnt] = v;
      num_cnt++;
      frac_cnt = 0;
      return 1;
    endfunction

    function bit apply_top();
      logic signed [63:0] a, b, r, ia, ib;
      opc_t code;
      if (num_cnt < 2 || op_cnt == 0) return 0;
      a = nums[num_cnt-1];
      b = nums[num_cnt-2];
      code = ops[op_cnt-1];
      num_cnt -= 2;
      op_cnt--;
      case (code)
        OPC_ADD: r = b + a;
        OPC_SUB: r = b - a;
        OPC_MUL: r = (b * a) / (64'sd1 <<< FRAC);
        OPC_DIV: begin
          if (a == 0) return 0;
          r = (b <<< FRAC) / a;
        end
        OPC_MOD: begin
          ia = a / (64'sd1 <<< FRAC);
          ib = b / (64'sd1 <<< FRAC);
          if (ia == 0) return 0;
          r = (ib % ia) <<< FRAC;
        end
        default: return 0;
      endcase
      nums[num_cnt] = clamp(r);
      num_cnt++;
      return 1;
    endfunction

    function bit push_operator(input opc_t code);
      while (op_cnt > 0 && code != OPC_LPAR && !(level(code) > level(ops[op_cnt-1])))
        if (!apply_top()) return 0;
      if (op_cnt >= DEPTH) return 0;
      ops[op_cnt] = code;
      op_cnt++;
      return 1;
    endfunction

    function bit close_group();
      forever begin
        if (op_cnt == 0) return 0;
        if (ops[op_cnt-1] == OPC_LPAR) begin
          op_cnt--;
          return 1;
        end
        if (!apply_top()) return 0;
      end
    endfunction

    // Accepted character: update state, queue a result on newline
    function void note_char(input logic [7:0] c);
      bit ok;
      line_result_t res;
      logic signed [63:0] top, pw;
      logic [63:0] d;
      ok = 1;
      if (c == CH_NL) begin
        res.value = '0;
        if (dropping) ok = 0;
        else begin
          while (ok && op_cnt > 0) ok = apply_top();
          if (ok && num_cnt == 0) ok = 0;
          if (ok) res.value = nums[num_cnt-1];
        end
        res.status = !ok;
        if (!ok) res.value = '0;
        dropping = 0;
        clear_stacks();
        pending.push_back(res);
        return;
      end
      if (dropping) return;
      if (c >= CH_0 && c <= CH_9) begin
        d = c - CH_0;
        if ((ps == PS_INT || ps == PS_FRAC) && num_cnt > 0) begin
          top = nums[num_cnt-1];
          if (ps == PS_INT) top = top * 10 + (d << FRAC);
          else if (frac_cnt < 15) begin
            frac_cnt++;
            pw = 1;
            for (int k = 0; k < frac_cnt; k++) pw = pw * 10;
            top = top + ((d << FRAC) / pw);
          end
          nums[num_cnt-1] = clamp(top);
        end else if (ps == PS_OPER || ps == PS_LPAR || ps == PS_START) begin
          ok = push_number(d << FRAC);
          ps = PS_INT;
        end
      end else if (c == CH_DOT) begin
        if (ps == PS_INT) ps = PS_FRAC;
      end else if (c == CH_LPAR) begin
        if (ps == PS_OPER || ps == PS_START || ps == PS_LPAR) begin
          ok = push_operator(OPC_LPAR);
          ps = PS_LPAR;
        end
      end else if (c == CH_MINUS) begin
        if (ps == PS_START || ps == PS_LPAR) begin
          ok = push_number('0);
          if (ok) ok = push_operator(OPC_SUB);
          ps = PS_OPER;
        end else if (ps == PS_INT || ps == PS_FRAC || ps == PS_RPAR) begin
          ok = push_operator(OPC_SUB);
          ps = PS_OPER;
        end
      end else if (c == CH_PLUS || c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
        if (ps == PS_INT || ps == PS_FRAC || ps == PS_RPAR) begin
          ok = push_operator(c == CH_PLUS ? OPC_ADD : c == CH_STAR ? OPC_MUL :
                             c == CH_SLASH ? OPC_DIV : OPC_MOD);
          ps = PS_OPER;
        end
      end else if (c == CH_RPAR) begin
        if (ps == PS_INT || ps == PS_FRAC || ps == PS_RPAR) begin
          ok = close_group();
          ps = PS_RPAR;
        end
      end
      if (!ok) begin
        clear_stacks();
        dropping = 1;
      end
    endfunction

    // Returned result against the oldest pending one
    function void check_result(input logic [31:0] value, input logic status);
      line_result_t exp_res;
      lines_done++;
      if (status) error_lines++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result value=%h status=%0d", value, status);
        return;
      end
      exp_res = pending.pop_front();
      if (exp_res.value !== value || exp_res.status !== status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: line %0d expected value=%h status=%0d, got value=%h status=%0d",
                   lines_done, exp_res.value, exp_res.status, value, status);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [1:0]  cfg_data;

  line_scoreboard sb;
  int  send_idle_pct;     // sender gap odds per cycle
  int  recv_stall_pct;    // receiver stall odds per cycle
  int  hold_reqs;         // long hold-off requests, raised by the stimulus
  int  hold_seen;         // requests taken up by the receiver
  int  hold_left;         // hold-off cycles left, counted in the receiver process
  int  chars_sent;
  longint cycles;

  infix_expression_evaluator DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= 0;
      hold_left     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser[0]);
      if (hold_reqs != hold_seen) begin
        hold_seen     <= hold_reqs;
        hold_left     <= HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Send one character, with random idle cycles before it; valid stays up after it
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Stop sending, wait until every pending result is in, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.prec[idx] = val;
  endtask

  task automatic set_prec(input logic [1:0] a, input logic [1:0] m, input logic [1:0] r);
    write_reg(CFG_PREC_ADD_SUB, a);
    write_reg(CFG_PREC_MUL_DIV, m);
    write_reg(CFG_PREC_MOD, r);
    cfg_valid <= 1'b0;
  endtask

  function automatic string rand_number();
    string s;
    int n;
    s = "";
    n = $urandom_range(3, 1);
    if ($urandom_range(19) == 0) n = $urandom_range(7, 5);
    repeat (n) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
    if ($urandom_range(2) == 0) begin
      s = {s, "."};
      repeat ($urandom_range(4)) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
      if ($urandom_range(19) == 0) s = {s, "123456789012345678"};
    end
    return s;
  endfunction

  // Random well-formed expression text, nesting bounded by depth
  function automatic string rand_expr(input int lvl);
    string s, ops;
    int terms;
    ops = "+-*/%";
    s = "";
    terms = $urandom_range(3, 1);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) s = {s, string'(ops[$urandom_range(4)])};
      if ($urandom_range(5) == 0) s = {s, "-"};
      if (lvl < 3 && $urandom_range(3) == 0) s = {s, "(", rand_expr(lvl + 1), ")"};
      else s = {s, rand_number()};
      if ($urandom_range(9) == 0) s = {s, " "};
    end
    return s;
  endfunction

  task automatic random_lines(input int nchars);
    string s;
    int start;
    start = chars_sent;
    while (chars_sent - start < nchars) begin
      case ($urandom_range(9))
        0: begin  // noise line: any byte but newline
          repeat ($urandom_range(12, 1)) begin
            s = string'(8'($urandom_range(255)));
            if (s[0] != CH_NL) send_text(s);
          end
        end
        1: begin  // broken: cut a good line and add stray parens
          s = rand_expr(0);
          s = s.substr(0, $urandom_range(s.len() - 1));
          send_text($urandom_range(1) ? {"(", s} : {s, "))"});
        end
        default: send_text(rand_expr(0));
      endcase
      send_char(CH_NL);
    end
  endtask

  initial begin
    sb = new();
    sb.init();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs = 0;
    chars_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: operators, unary minus, parens, errors, saturation, fractions
    send_text("1+2*3-4/2%3\n");
    send_text("-(7.5)*(2)\n");
    send_text("((1+2))\n");
    send_text("5/0\n");
    send_text("5%0.5\n");
    send_text("3)\n");
    send_text("(3\n");
    send_text("\n");
    send_text("99999*99999\n");
    send_text("-99999*99999\n");
    send_text("1.1234567890123456789\n");
    send_text("7 % -3 ab.\n");
    send_text("((((((((((((((((((((((((((((((((((1\n");
    send_text("\xFF+\x80 2\n");
    drain();

    // Precedence extremes, every register
    set_prec(2'd3, 2'd0, 2'd0);
    send_text("2*3+4%3\n");
    drain();
    set_prec(2'd0, 2'd3, 2'd1);
    send_text("2+3*4-1%2\n");
    drain();
    set_prec(2'd1, 2'd2, 2'd3);

    // Random phases with various idling
    send_idle_pct = 0;  recv_stall_pct = 0;  random_lines(140);
    send_idle_pct = 61; recv_stall_pct = 0;  random_lines(140);
    drain();
    set_prec(2'd2, 2'd2, 2'd0);
    send_idle_pct = 0;  recv_stall_pct = 61; random_lines(140);
    drain();
    set_prec($urandom_range(3), $urandom_range(3), $urandom_range(3));
    send_idle_pct = 61; recv_stall_pct = 61; random_lines(140);

    // Long hold-off while short lines keep coming, so the input stalls
    drain();
    set_prec(2'd1, 2'd2, 2'd3);
    send_idle_pct = 0;  recv_stall_pct = 10;
    hold_reqs++;
    repeat (20) send_text("1\n");
    send_idle_pct = 10;
    random_lines(90);

    drain();
    $display("tb: %0d characters sent, %0d lines checked (%0d error lines)",
             chars_sent, sb.lines_done, sb.error_lines);
    $display("tb: precedence settings incl. extremes, four idling phases, long stall");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> infix_expression_evaluator.f
rtl/core/iee_pkg.sv
rtl/core/iee_div.sv
rtl/core/infix_expression_evaluator.sv
dv/testbench.sv
